### hw/rtl/xsp_pkg.sv
package xsp_pkg;

    localparam int IN_FRAC_BITS   = 12;
    localparam int COEF_FRAC_BITS = 14;
    localparam int LIN_FRAC_BITS  = 16;

    localparam int IN_W          = 16;
    localparam int OUT_W         = 8;
    localparam int COEF_W        = COEF_FRAC_BITS + 3;
    localparam int PROD_W        = IN_W + 1 + COEF_W;
    localparam int SUM_W         = PROD_W + 2;
    localparam int LIN_W         = LIN_FRAC_BITS + 1;
    localparam int LIN_SHIFT     = IN_FRAC_BITS + COEF_FRAC_BITS - LIN_FRAC_BITS;
    localparam int NUM_LANES     = 3;
    localparam int NUM_TERMS     = 3;
    localparam int NUM_CODES     = 1 << OUT_W;
    localparam int SEARCH_STAGES = OUT_W;
    localparam int BIG_W         = 512;

    localparam longint unsigned CURVE_Q   = 64'd269026055;
    localparam longint unsigned CURVE_OFS = 64'd14025055;
    localparam longint unsigned KNEE_E7   = 64'd31308;
    localparam longint unsigned SLOPE_E5  = 64'd329461292;

    typedef logic [IN_W-1:0]          pix_t;
    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic [LIN_W-1:0]         lin_t;
    typedef logic [OUT_W-1:0]         code_t;
    typedef logic [BIG_W-1:0]         big_t;
    typedef lin_t                     thr_rom_t [NUM_CODES];
    typedef coef_t                    coef_mat_t [NUM_LANES*NUM_TERMS];

    // srgb matrix in units of 1e-4, row major
    localparam int MAT_E4 [NUM_LANES*NUM_TERMS] = '{
        32406, -15372, -4986,
        -9689,  18758,   415,
          557,  -2040, 10570
    };

    // round half away from zero to COEF_FRAC_BITS fraction bits
    function automatic coef_t coef_q(int m);
        longint unsigned mag;
        longint unsigned c;
        mag = (m < 0) ? longint'(-m) : longint'(m);
        c   = ((mag << COEF_FRAC_BITS) + 64'd5000) / 64'd10000;
        return (m < 0) ? coef_t'(-c) : coef_t'(c);
    endfunction

    function automatic coef_mat_t build_coef();
        coef_mat_t t;
        for (int i = 0; i < NUM_LANES*NUM_TERMS; i++) begin
            t[i] = coef_q(MAT_E4[i]);
        end
        return t;
    endfunction

    localparam coef_mat_t COEF_MAT = build_coef();

    // exact test: floor(255.001 * g(n / 2^LIN_FRAC_BITS)) >= k
    function automatic bit curve_reaches(longint unsigned n, longint unsigned k);
        big_t            a;
        big_t            b;
        longint unsigned p;
        bit              res;
        if (n * 64'd10000000 <= (KNEE_E7 << LIN_FRAC_BITS)) begin
            res = (n * SLOPE_E5) >= ((64'd100000 * k) << LIN_FRAC_BITS);
        end else begin
            p = 64'd1000000 * k + CURVE_OFS;
            a = big_t'(1);
            for (int i = 0; i < 5; i++) a = a * big_t'(n);
            for (int i = 0; i < 12; i++) a = a * big_t'(CURVE_Q);
            b = big_t'(1);
            for (int i = 0; i < 12; i++) b = b * big_t'(p);
            b = b << (5 * LIN_FRAC_BITS);
            res = (a >= b);
        end
        return res;
    endfunction

    // smallest linear value that reaches each code
    function automatic thr_rom_t build_thr();
        thr_rom_t        t;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        t[0] = '0;
        for (int k = 1; k < NUM_CODES; k++) begin
            lo = 64'd0;
            hi = 64'd1 << LIN_FRAC_BITS;
            for (int it = 0; it <= LIN_W; it++) begin
                if (lo < hi) begin
                    mid = (lo + hi) >> 1;
                    if (curve_reaches(mid, longint'(k))) hi = mid;
                    else lo = mid + 64'd1;
                end
            end
            t[k] = lin_t'(lo);
        end
        return t;
    endfunction

    localparam thr_rom_t GAMMA_THR = build_thr();

endpackage

### hw/rtl/xyz_to_srgb8_pixel.sv
// xyz to 8-bit srgb pixel converter
//
// input channel s_*: one pixel per transaction, x/y/z tristimulus as
// unsigned q4.12. output channel m_*: one transaction per input pixel,
// gamma-encoded red/green/blue bytes, in input order.
//
// each color channel has its own lane: a matrix row (multiply stage, then
// sum/round/clip stage) followed by an 8-stage binary search of the
// gamma threshold rom, one code bit per stage. a final register merges
// the three lane bytes into one output transaction.
// throughput: one pixel per cycle; the pipeline is fully stall-free while
// m_ready is high.
// when the receiver holds m_ready low with m_valid high, the whole pipeline
// freezes and s_ready drops in the same cycle; nothing is lost or repeated.
// reset (aresetn low, synchronous) empties the pipeline; m_valid goes low.
module xyz_to_srgb8_pixel (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  xsp_pkg::pix_t   s_x_in,
    input  xsp_pkg::pix_t   s_y_in,
    input  xsp_pkg::pix_t   s_z_in,
    output logic            m_valid,
    input  logic            m_ready,
    output xsp_pkg::code_t  m_red,
    output xsp_pkg::code_t  m_green,
    output xsp_pkg::code_t  m_blue
);
    import xsp_pkg::*;

    localparam int LATENCY = 2 + SEARCH_STAGES + 1;

    logic               en;
    logic [LATENCY-1:0] vld_reg;
    logic [LATENCY-1:0] vld_next;
    coef_t              coef_row  [NUM_LANES][NUM_TERMS];
    lin_t               lane_lin  [NUM_LANES];
    code_t              lane_code [NUM_LANES];
    code_t              red_reg;
    code_t              green_reg;
    code_t              blue_reg;

    assign en      = !vld_reg[LATENCY-1] || m_ready;
    assign s_ready = en;

    generate
        for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
            for (genvar j = 0; j < NUM_TERMS; j++) begin : g_coef
                assign coef_row[l][j] = COEF_MAT[l*NUM_TERMS + j];
            end

            xsp_lin_row u_lin_row (
                .aclk (aclk),
                .en   (en),
                .x_in (s_x_in),
                .y_in (s_y_in),
                .z_in (s_z_in),
                .coef (coef_row[l]),
                .lin  (lane_lin[l])
            );

            xsp_gamma_search u_search (
                .aclk (aclk),
                .en   (en),
                .lin  (lane_lin[l]),
                .code (lane_code[l])
            );
        end
    endgenerate

    assign vld_next = {vld_reg[LATENCY-2:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    // merge the lane bytes into the output register
    always_ff @(posedge aclk) begin
        if (en) begin
            red_reg   <= lane_code[0];
            green_reg <= lane_code[1];
            blue_reg  <= lane_code[2];
        end
    end

    assign m_valid = vld_reg[LATENCY-1];
    assign m_red   = red_reg;
    assign m_green = green_reg;
    assign m_blue  = blue_reg;

endmodule

### hw/rtl/xsp_lin_row.sv
module xsp_lin_row (
    input  logic                    aclk,
    input  logic                    en,
    input  xsp_pkg::pix_t           x_in,
    input  xsp_pkg::pix_t           y_in,
    input  xsp_pkg::pix_t           z_in,
    input  xsp_pkg::coef_t          coef [xsp_pkg::NUM_TERMS],
    output xsp_pkg::lin_t           lin
);
    import xsp_pkg::*;

    localparam int WIDE_W = SUM_W + 2;
    localparam lin_t LIN_ONE = lin_t'(1) << LIN_FRAC_BITS;

    logic signed [PROD_W-1:0] prod_reg  [NUM_TERMS];
    logic signed [PROD_W-1:0] prod_next [NUM_TERMS];
    pix_t                     pix       [NUM_TERMS];
    logic signed [SUM_W-1:0]  sum;
    logic [WIDE_W-1:0]        mag;
    logic [WIDE_W-1:0]        rnd;
    lin_t                     lin_reg;
    lin_t                     lin_next;

    assign pix[0] = x_in;
    assign pix[1] = y_in;
    assign pix[2] = z_in;

    always_comb begin
        for (int j = 0; j < NUM_TERMS; j++) begin
            prod_next[j] = $signed({1'b0, pix[j]}) * coef[j];
        end
    end

    always_comb begin
        sum = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1]) + SUM_W'(prod_reg[2]);
        mag = WIDE_W'($unsigned(sum));
    end

    generate
        if (LIN_SHIFT > 0) begin : g_round
            // drop fraction bits, round half up
            assign rnd = (mag + (WIDE_W'(1) << (LIN_SHIFT - 1))) >> LIN_SHIFT;
        end else if (LIN_SHIFT < 0) begin : g_widen
            assign rnd = mag << (-LIN_SHIFT);
        end else begin : g_same
            assign rnd = mag;
        end
    endgenerate

    always_comb begin
        if (sum <= 0) begin
            lin_next = '0;
        end else if (rnd > WIDE_W'(LIN_ONE)) begin
            lin_next = LIN_ONE;
        end else begin
            lin_next = rnd[LIN_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
            lin_reg  <= lin_next;
        end
    end

    assign lin = lin_reg;

endmodule

### hw/rtl/xsp_gamma_search.sv
module xsp_gamma_search (
    input  logic            aclk,
    input  logic            en,
    input  xsp_pkg::lin_t   lin,
    output xsp_pkg::code_t  code
);
    import xsp_pkg::*;

    // one code bit per stage, msb first
    code_t code_reg  [SEARCH_STAGES];
    code_t code_next [SEARCH_STAGES];
    lin_t  lin_reg   [SEARCH_STAGES-1];
    lin_t  lin_stage [SEARCH_STAGES];
    code_t code_prev [SEARCH_STAGES];
    code_t cand      [SEARCH_STAGES];

    generate
        for (genvar i = 0; i < SEARCH_STAGES; i++) begin : g_stage
            if (i == 0) begin : g_first
                assign lin_stage[i] = lin;
                assign code_prev[i] = '0;
            end else begin : g_next
                assign lin_stage[i] = lin_reg[i-1];
                assign code_prev[i] = code_reg[i-1];
            end

            assign cand[i] = code_prev[i] | (code_t'(1) << (OUT_W - 1 - i));

            always_comb begin
                if (lin_stage[i] >= GAMMA_THR[cand[i]]) begin
                    code_next[i] = cand[i];
                end else begin
                    code_next[i] = code_prev[i];
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    code_reg[i] <= code_next[i];
                end
            end

            if (i < SEARCH_STAGES - 1) begin : g_carry
                always_ff @(posedge aclk) begin
                    if (en) begin
                        lin_reg[i] <= lin_stage[i];
                    end
                end
            end
        end
    endgenerate

    assign code = code_reg[SEARCH_STAGES-1];

endmodule
